/* sv/sfs_pkg.sv */
// ----------------------------------------------------------------------------
// sfs_pkg
// Types and constants shared by the sprite frame sequencer modules.
// ----------------------------------------------------------------------------
package sfs_pkg;

  // field widths
  localparam int CMD_W      = 3;
  localparam int TCK_W      = 8;
  localparam int CNT_W      = 9;
  localparam int FRM_W      = 8;
  localparam int SPD_W      = 16;
  localparam int LOOP_W     = 16;
  localparam int EV_W       = 2;
  localparam int DELTA_W    = SPD_W + TCK_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK      = 3'd0,
    CMD_GOTO_PLAY = 3'd1,
    CMD_GOTO_STOP = 3'd2,
    CMD_RUN_TO    = 3'd3,
    CMD_PAUSE     = 3'd4,
    CMD_RESUME    = 3'd5
  } cmd_e;

  // event codes
  typedef enum logic [EV_W-1:0] {
    EV_NONE   = 2'd0,
    EV_FIRST  = 2'd1,
    EV_LAST   = 2'd2,
    EV_TARGET = 2'd3
  } event_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_COUNT  = 3'd0,
    CFG_SPEED        = 3'd1,
    CFG_REVERSE      = 3'd2,
    CFG_REPEAT_COUNT = 3'd3,
    CFG_EVENT_ENABLE = 3'd4
  } cfg_idx_e;

  // live configuration (frame count already saturated)
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [SPD_W-1:0] speed;
    logic             reverse;
    logic             event_en;
  } cfg_t;

  // repeat count write, reloads the loop counter
  typedef struct packed {
    logic                     en;
    logic signed [LOOP_W-1:0] value;
  } loop_ld_t;

  // decoded request from the front
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [DELTA_W-1:0] delta;
    logic               tick_zero;
    logic [CNT_W-1:0]   goal;
    logic               goal_ok;
  } op_t;

  // queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* sv/sfs_front.sv */
// ----------------------------------------------------------------------------
// sfs_front
// Accepts requests, decodes the goto frame and forms the tick step product.
// ----------------------------------------------------------------------------
module sfs_front (
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           command_i,
  input  logic [7:0]           elapsed_ticks_i,
  input  logic [8:0]           frame_number_i,
  input  sfs_pkg::cfg_t        cfg_i,
  input  sfs_pkg::q_stat_t     q_stat_i,
  output logic                 push_o,
  output sfs_pkg::op_t         op_o
);
  import sfs_pkg::*;

  logic [CNT_W-1:0] goal;

  // take a request whenever the queue has room
  assign in_ready_o = !q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  // one-based frame to zero-based, zero stays at the first frame
  assign goal = (frame_number_i == '0) ? '0 : frame_number_i - CNT_W'(1);

  // classify and precompute
  always_comb begin
    op_o.cmd       = command_i;
    op_o.delta     = DELTA_W'(cfg_i.speed) * DELTA_W'(elapsed_ticks_i);
    op_o.tick_zero = (elapsed_ticks_i == '0);
    op_o.goal      = goal;
    op_o.goal_ok   = (goal < cfg_i.count);
  end

endmodule

/* sv/sfs_queue.sv */
// ----------------------------------------------------------------------------
// sfs_queue
// Short register queue of decoded requests between front and back.
// ----------------------------------------------------------------------------
module sfs_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sfs_pkg::op_t     op_i,
  input  logic             pop_i,
  output sfs_pkg::op_t     op_o,
  output sfs_pkg::q_stat_t stat_o
);
  import sfs_pkg::*;

  op_t              mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign op_o         = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

/* sv/sfs_back.sv */
// ----------------------------------------------------------------------------
// sfs_back
// Carries out queued requests on the animation state, holds the result.
// ----------------------------------------------------------------------------
module sfs_back #(
  parameter int FRAC_BITS = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sfs_pkg::cfg_t        cfg_i,
  input  sfs_pkg::loop_ld_t    loop_ld_i,
  input  sfs_pkg::op_t         op_i,
  input  sfs_pkg::q_stat_t     q_stat_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           frame_index_o,
  output logic [1:0]           event_res_o,
  output logic                 paused_o,
  output logic signed [15:0]   repeats_left_o
);
  import sfs_pkg::*;

  // headroom for count in fixed point plus one step, and a sign
  localparam int MAG_W = (CNT_W + FRAC_BITS > DELTA_W) ? CNT_W + FRAC_BITS : DELTA_W;
  localparam int POS_W = MAG_W + 2;

  // animation state
  logic signed [POS_W-1:0]  pos_q, pos_d;
  logic [CNT_W-1:0]         frame_q, frame_d;
  logic signed [LOOP_W-1:0] loops_q, loops_d;
  logic                     pause_q, pause_d;
  logic                     run_q, run_d;
  logic [CNT_W-1:0]         target_q, target_d;
  event_e                   ev;

  // result register
  logic                     out_valid_q;
  logic [FRM_W-1:0]         res_frame_q;
  event_e                   res_ev_q;
  logic                     res_pause_q;
  logic signed [LOOP_W-1:0] res_loops_q;

  // tick datapath
  logic [CNT_W-1:0]        last;
  logic signed [POS_W-1:0] fix_count, fix_last, fix_target, fix_goal, delta, sum, ip;
  logic                    neg, hit, idle, loops_pos;

  assign pop_o = !q_stat_i.empty && (!out_valid_q || out_ready_i);

  assign last       = cfg_i.count - CNT_W'(1);
  assign fix_count  = $signed(POS_W'(cfg_i.count) << FRAC_BITS);
  assign fix_last   = $signed(POS_W'(last) << FRAC_BITS);
  assign fix_target = $signed(POS_W'(target_q) << FRAC_BITS);
  assign fix_goal   = $signed(POS_W'(op_i.goal) << FRAC_BITS);
  assign delta      = $signed(POS_W'(op_i.delta));
  assign sum        = cfg_i.reverse ? pos_q - delta : pos_q + delta;
  assign neg        = sum[POS_W-1];
  assign ip         = sum >>> FRAC_BITS;
  assign loops_pos  = !loops_q[LOOP_W-1] && (loops_q != '0);

  // truncation toward zero meets the target; a small negative truncates to zero
  assign hit = run_q && (neg ? ((target_q == '0) && (&ip) && (sum[FRAC_BITS-1:0] != '0))
                             : (ip == $signed(POS_W'(target_q))));

  assign idle = (cfg_i.count <= CNT_W'(1)) || pause_q || op_i.tick_zero || (loops_q == '0);

  // next state for one request
  always_comb begin
    pos_d    = pos_q;
    frame_d  = frame_q;
    loops_d  = loops_q;
    pause_d  = pause_q;
    run_d    = run_q;
    target_d = target_q;
    ev       = EV_NONE;
    case (cmd_e'(op_i.cmd))
      CMD_TICK: begin
        if (!idle) begin
          pos_d = sum;
          if (neg) begin
            frame_d = '0;
          end else if (ip > $signed(POS_W'(last))) begin
            frame_d = last;
          end else begin
            frame_d = ip[CNT_W-1:0];
          end
          if (hit) begin
            run_d   = 1'b0;
            frame_d = target_q;
            pos_d   = fix_target;
            pause_d = 1'b1;
            ev      = EV_TARGET;
          end else if (!cfg_i.reverse && (sum >= fix_count)) begin
            pos_d   = '0;
            frame_d = '0;
            if (loops_pos) begin
              loops_d = loops_q - LOOP_W'(1);
            end
            ev = EV_FIRST;
          end else if (cfg_i.reverse && neg) begin
            pos_d   = fix_count;
            frame_d = last;
            if (loops_pos) begin
              loops_d = loops_q - LOOP_W'(1);
            end
            ev = EV_LAST;
          end else if (neg) begin
            pos_d   = fix_last;
            frame_d = last;
            ev      = EV_LAST;
          end
        end
      end
      CMD_GOTO_PLAY, CMD_GOTO_STOP: begin
        if (op_i.goal_ok) begin
          frame_d = op_i.goal;
          pos_d   = fix_goal;
          pause_d = 1'b0;
        end
        if (cmd_e'(op_i.cmd) == CMD_GOTO_STOP) begin
          pause_d = 1'b1;
        end
      end
      CMD_RUN_TO: begin
        if (op_i.goal_ok) begin
          target_d = op_i.goal;
          run_d    = 1'b1;
          pause_d  = 1'b0;
        end
      end
      CMD_PAUSE:  pause_d = 1'b1;
      CMD_RESUME: pause_d = 1'b0;
      default: ;
    endcase
    if (!cfg_i.event_en) begin
      ev = EV_NONE;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      frame_q  <= '0;
      loops_q  <= '1;
      pause_q  <= 1'b0;
      run_q    <= 1'b0;
      target_q <= '0;
    end else begin
      if (loop_ld_i.en) begin
        loops_q <= loop_ld_i.value;
      end else if (pop_o) begin
        loops_q <= loops_d;
      end
      if (pop_o) begin
        pos_q    <= pos_d;
        frame_q  <= frame_d;
        pause_q  <= pause_d;
        run_q    <= run_d;
        target_q <= target_d;
      end
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_frame_q <= frame_d[FRM_W-1:0];
      res_ev_q    <= ev;
      res_pause_q <= pause_d;
      res_loops_q <= loops_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_index_o  = res_frame_q;
  assign event_res_o    = res_ev_q;
  assign paused_o       = res_pause_q;
  assign repeats_left_o = res_loops_q;

endmodule

/* sv/sprite_frame_sequencer_top.sv */
// ----------------------------------------------------------------------------
// sprite_frame_sequencer_top
// Sprite animation frame counter with a fixed-point play position.
// ----------------------------------------------------------------------------
// Takes one request per clock while the queue has room, and returns one result
// per request, in order. The front decodes and multiplies speed by elapsed
// ticks into a two-entry queue, and the back applies the position update, wrap
// and target checks to one request at a time and registers its result. The back
// takes no request while an untaken result fills its result slot; otherwise it
// sustains one request per cycle. Configuration writes take effect at once and
// must come while the block is idle; a repeat count write also reloads the
// remaining loops. No clearing pass follows reset.
module sprite_frame_sequencer_top #(
  parameter int MAX_FRAMES = 256,
  parameter int FRAC_BITS  = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  // request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         command_i,
  input  logic [7:0]         elapsed_ticks_i,
  input  logic [8:0]         frame_number_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         frame_index_o,
  output logic [1:0]         event_res_o,
  output logic               paused_o,
  output logic signed [15:0] repeats_left_o
);
  import sfs_pkg::*;

  cfg_t     cfg_q;
  loop_ld_t loop_ld;
  op_t      front_op, queue_op;
  q_stat_t  q_stat;
  logic     push, pop;

  // repeat count write goes straight to the loop counter
  assign loop_ld.en    = cfg_we_i && (cfg_idx_e'(cfg_index_i) == CFG_REPEAT_COUNT);
  assign loop_ld.value = $signed(cfg_data_i[LOOP_W-1:0]);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.count    <= CNT_W'(1);
      cfg_q.speed    <= SPD_W'(66);
      cfg_q.reverse  <= 1'b0;
      cfg_q.event_en <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FRAME_COUNT: begin
          if (32'(cfg_data_i[CNT_W-1:0]) > MAX_FRAMES) begin
            cfg_q.count <= CNT_W'(MAX_FRAMES);
          end else begin
            cfg_q.count <= cfg_data_i[CNT_W-1:0];
          end
        end
        CFG_SPEED:        cfg_q.speed    <= cfg_data_i[SPD_W-1:0];
        CFG_REVERSE:      cfg_q.reverse  <= cfg_data_i[0];
        CFG_EVENT_ENABLE: cfg_q.event_en <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  sfs_front u_front (
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .elapsed_ticks_i (elapsed_ticks_i),
    .frame_number_i  (frame_number_i),
    .cfg_i           (cfg_q),
    .q_stat_i        (q_stat),
    .push_o          (push),
    .op_o            (front_op)
  );

  sfs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .op_i   (front_op),
    .pop_i  (pop),
    .op_o   (queue_op),
    .stat_o (q_stat)
  );

  sfs_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .loop_ld_i      (loop_ld),
    .op_i           (queue_op),
    .q_stat_i       (q_stat),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_index_o  (frame_index_o),
    .event_res_o    (event_res_o),
    .paused_o       (paused_o),
    .repeats_left_o (repeats_left_o)
  );

  // a reached target always leaves the animation paused
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o == EV_TARGET) |-> paused_o)
    else $error("target event without pause");

  // events are silenced when reporting is off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o != EV_NONE) |-> cfg_q.event_en)
    else $error("event reported while disabled");

  // the back only drains the queue when the result slot frees up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !pop)
    else $error("queue popped into a full result slot");

  // a result is only dropped after it was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("result lost");

endmodule
